// File: rtl/char_lcd_four_bit_sequencer_macros.svh
// assertion macros for the character lcd sequencer
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef CHAR_LCD_FOUR_BIT_SEQUENCER_MACROS_SVH
`define CHAR_LCD_FOUR_BIT_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define CLCD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition on one edge that implies a property on the next edge
`define CLCD_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`else

`define CLCD_ASSERT(name, prop, msg)
`define CLCD_ASSERT_NEXT(name, pre, post, msg)

`endif

`endif

// File: rtl/clcd_pkg.sv
// types, constants and helper functions of the character lcd sequencer
// no dependencies; used by every module of the block
package clcd_pkg;

  // grid of the panel
  localparam int unsigned COLUMNS = 20;
  localparam int unsigned ROWS    = 4;

  // width of the wait counter, set by the widest timing register
  localparam int unsigned WAIT_W = 17;

  // request codes on the input channel
  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_INIT      = 3'd1,
    CMD_BYTE      = 3'd2,
    CMD_DATA      = 3'd3,
    CMD_CURSOR    = 3'd4,
    CMD_DISPLAY   = 3'd5,
    CMD_BACKLIGHT = 3'd6
  } cmd_e;

  // timing register indexes
  typedef enum logic [2:0] {
    REG_PULSE       = 3'd0,
    REG_NIBBLE_GAP  = 3'd1,
    REG_CMD_DELAY   = 3'd2,
    REG_CLEAR_DELAY = 3'd3,
    REG_POWERUP     = 3'd4,
    REG_INIT_LONG   = 3'd5,
    REG_INIT_SHORT  = 3'd6,
    REG_INIT_CMD    = 3'd7
  } cfg_idx_e;

  // sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_POWERUP   = 4'd1,
    PH_INIT_EHI  = 4'd2,
    PH_INIT_ELO  = 4'd3,
    PH_INIT_WAIT = 4'd4,
    PH_SETUP     = 4'd5,
    PH_EHI       = 4'd6,
    PH_ELO       = 4'd7,
    PH_GAP       = 4'd8,
    PH_POST      = 4'd9,
    PH_EXTRA     = 4'd10
  } phase_e;

  // init step numbering: 1..4 wake-up nibbles, 5..9 init commands
  localparam logic [3:0] STEP_NONE      = 4'd0;
  localparam logic [3:0] STEP_FIRST_NIB = 4'd1;
  localparam logic [3:0] STEP_LAST_NIB  = 4'd4;
  localparam logic [3:0] STEP_FIRST_CMD = 4'd5;
  localparam logic [3:0] STEP_SLOW_CMD  = 4'd6;
  localparam logic [3:0] STEP_LAST_CMD  = 4'd9;

  localparam logic [3:0] NIB_WAKE  = 4'h3;
  localparam logic [3:0] NIB_4BIT  = 4'h2;
  localparam logic [7:0] CMD_FUNC_SET = 8'h28;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] CMD_DISP_CTRL = 8'h08;

  // timing registers
  typedef struct packed {
    logic [7:0]        pulse_us;
    logic [11:0]       nibble_gap_us;
    logic [11:0]       cmd_delay_us;
    logic [15:0]       clear_delay_us;
    logic [WAIT_W-1:0] powerup_wait_us;
    logic [15:0]       init_long_wait_us;
    logic [15:0]       init_short_wait_us;
    logic [15:0]       init_cmd_wait_us;
  } clcd_cfg_t;

  // one tick with its optional request
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] value;
    logic [7:0] col;
    logic [7:0] line;
    logic       disp_en;
    logic       curs_en;
    logic       blink_en;
    logic       backlight_on;
  } clcd_req_t;

  // pin levels and status for one tick
  typedef struct packed {
    logic       rs_pin;
    logic       enable_pin;
    logic [3:0] data_pins;
    logic       backlight_pin;
    logic       busy_res;
    logic       rejected;
  } clcd_res_t;

  // sequencer state
  typedef struct packed {
    phase_e            phase;
    logic [WAIT_W-1:0] wait_count;
    logic [7:0]        pending_byte;
    logic              select_latch;
    logic              low_half_next;
    logic [3:0]        init_step;
    logic              post_long;
    logic              backlight_level;
    logic              pin_rs;
    logic              pin_e;
    logic [3:0]        pin_data;
  } clcd_state_t;

  // ddram address of the first column of a row
  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] base;
    unique case (row)
      2'd0: base = 8'h00;
      2'd1: base = 8'h40;
      2'd2: base = 8'h14;
      2'd3: base = 8'h54;
      default: base = 8'h00;
    endcase
    return base;
  endfunction

  // command bytes sent after the wake-up nibbles
  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] cmd;
    unique case (idx)
      3'd0:    cmd = CMD_FUNC_SET;
      3'd1:    cmd = 8'h08;
      3'd2:    cmd = CMD_CLEAR;
      3'd3:    cmd = 8'h06;
      3'd4:    cmd = 8'h0C;
      default: cmd = 8'h0C;
    endcase
    return cmd;
  endfunction

endpackage

// File: rtl/clcd_req_if.sv
// input channel of the lcd sequencer: one tick with an optional request
// stands alone; field widths follow the request fields
interface clcd_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] value;
  logic [7:0] col;
  logic [7:0] line;
  logic       disp_en;
  logic       curs_en;
  logic       blink_en;
  logic       backlight_on;

  modport source (
    output valid, command, value, col, line, disp_en, curs_en, blink_en, backlight_on,
    input  ready
  );

  modport sink (
    input  valid, command, value, col, line, disp_en, curs_en, blink_en, backlight_on,
    output ready
  );
endinterface

// File: rtl/clcd_res_if.sv
// output channel of the lcd sequencer: pin levels and status of one tick
// stands alone; field widths follow the result fields
interface clcd_res_if;
  logic       valid;
  logic       ready;
  logic       rs_pin;
  logic       enable_pin;
  logic [3:0] data_pins;
  logic       backlight_pin;
  logic       busy_res;
  logic       rejected;

  modport source (
    output valid, rs_pin, enable_pin, data_pins, backlight_pin, busy_res, rejected,
    input  ready
  );

  modport sink (
    input  valid, rs_pin, enable_pin, data_pins, backlight_pin, busy_res, rejected,
    output ready
  );
endinterface

// File: rtl/clcd_cfg.sv
// timing register bank of the lcd sequencer
// depends on clcd_pkg
module clcd_cfg
  import clcd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [WAIT_W-1:0] cfg_wdata_i,
  output clcd_cfg_t         cfg_o
);

  clcd_cfg_t cfg_q;
  clcd_cfg_t cfg_d;

  // write decode, data truncated to the register width
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_PULSE:       cfg_d.pulse_us           = cfg_wdata_i[7:0];
        REG_NIBBLE_GAP:  cfg_d.nibble_gap_us      = cfg_wdata_i[11:0];
        REG_CMD_DELAY:   cfg_d.cmd_delay_us       = cfg_wdata_i[11:0];
        REG_CLEAR_DELAY: cfg_d.clear_delay_us     = cfg_wdata_i[15:0];
        REG_POWERUP:     cfg_d.powerup_wait_us    = cfg_wdata_i;
        REG_INIT_LONG:   cfg_d.init_long_wait_us  = cfg_wdata_i[15:0];
        REG_INIT_SHORT:  cfg_d.init_short_wait_us = cfg_wdata_i[15:0];
        REG_INIT_CMD:    cfg_d.init_cmd_wait_us   = cfg_wdata_i[15:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  // register bank with datasheet-style defaults
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_us           <= 8'd2;
      cfg_q.nibble_gap_us      <= 12'd50;
      cfg_q.cmd_delay_us       <= 12'd50;
      cfg_q.clear_delay_us     <= 16'd2000;
      cfg_q.powerup_wait_us    <= WAIT_W'(100000);
      cfg_q.init_long_wait_us  <= 16'd15000;
      cfg_q.init_short_wait_us <= 16'd5000;
      cfg_q.init_cmd_wait_us   <= 16'd2000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/clcd_step.sv
// next-state and pin logic of the lcd sequencer for one microsecond tick
// depends on clcd_pkg
module clcd_step
  import clcd_pkg::*;
(
  input  clcd_state_t state_i,
  input  clcd_cfg_t   cfg_i,
  input  clcd_req_t   req_i,
  output clcd_state_t state_o,
  output clcd_res_t   res_o
);

  clcd_state_t s;
  logic        is_req;
  logic        rejected;
  logic [1:0]  cur_row;
  logic [7:0]  cur_col;
  logic [7:0]  cur_addr;
  logic [7:0]  cursor_byte;
  logic [7:0]  disp_byte;

  // a zero timing value still lasts one tick
  function automatic logic [WAIT_W-1:0] load_wait(input logic [WAIT_W-1:0] c);
    return (c == '0) ? WAIT_W'(1) : c;
  endfunction

  // latch a byte and start with the rs setup tick
  function automatic clcd_state_t start_byte(input clcd_state_t st, input logic [7:0] b,
                                             input logic is_data);
    clcd_state_t r;
    r               = st;
    r.pending_byte  = b;
    r.select_latch  = is_data;
    r.low_half_next = 1'b0;
    r.post_long     = !is_data && (b == CMD_CLEAR || b[7:1] == 7'h01);
    r.phase         = PH_SETUP;
    r.wait_count    = WAIT_W'(1);
    return r;
  endfunction

  // cursor address with row and column clamped to the grid
  always_comb begin
    cur_row     = (req_i.line >= 8'(ROWS)) ? 2'(ROWS - 1) : req_i.line[1:0];
    cur_col     = (req_i.col >= 8'(COLUMNS)) ? 8'(COLUMNS - 1) : req_i.col;
    cur_addr    = row_base(cur_row) + cur_col;
    cursor_byte = CMD_SET_DDRAM | {1'b0, cur_addr[6:0]};
    disp_byte   = CMD_DISP_CTRL | {5'b0, req_i.disp_en, req_i.curs_en, req_i.blink_en};
  end

  // request handling, then one tick of the running sequence
  always_comb begin
    s        = state_i;
    rejected = 1'b0;
    is_req   = (req_i.command != CMD_TICK) && (req_i.command <= CMD_BACKLIGHT);

    if (is_req && state_i.phase != PH_IDLE) begin
      rejected = 1'b1;
    end else if (is_req) begin
      unique case (cmd_e'(req_i.command))
        CMD_INIT: begin
          s.pin_rs          = 1'b0;
          s.pin_e           = 1'b0;
          s.pin_data        = 4'h0;
          s.backlight_level = 1'b1;
          s.init_step       = STEP_NONE;
          s.phase           = PH_POWERUP;
          s.wait_count      = load_wait(cfg_i.powerup_wait_us);
        end
        CMD_BYTE:      s = start_byte(s, req_i.value, 1'b0);
        CMD_DATA:      s = start_byte(s, req_i.value, 1'b1);
        CMD_CURSOR:    s = start_byte(s, cursor_byte, 1'b0);
        CMD_DISPLAY:   s = start_byte(s, disp_byte, 1'b0);
        CMD_BACKLIGHT: s.backlight_level = req_i.backlight_on;
        default:       s = state_i;
      endcase
    end

    if (s.phase != PH_IDLE) begin
      // pin levels for this tick
      unique case (s.phase)
        PH_INIT_EHI: begin
          s.pin_rs   = 1'b0;
          s.pin_e    = 1'b1;
          s.pin_data = (s.init_step == STEP_LAST_NIB) ? NIB_4BIT : NIB_WAKE;
        end
        PH_INIT_ELO, PH_ELO: s.pin_e = 1'b0;
        PH_SETUP: begin
          s.pin_rs = s.select_latch;
          s.pin_e  = 1'b0;
        end
        PH_EHI: begin
          s.pin_e    = 1'b1;
          s.pin_data = s.low_half_next ? s.pending_byte[3:0] : s.pending_byte[7:4];
        end
        default: s.pin_e = s.pin_e;
      endcase

      // count down the current phase
      if (s.wait_count != '0) begin
        s.wait_count = s.wait_count - WAIT_W'(1);
      end

      // phase transitions when the count runs out
      if (s.wait_count == '0) begin
        unique case (s.phase)
          PH_POWERUP: begin
            s.init_step  = STEP_FIRST_NIB;
            s.phase      = PH_INIT_EHI;
            s.wait_count = load_wait(WAIT_W'(cfg_i.pulse_us));
          end
          PH_INIT_EHI: begin
            s.phase      = PH_INIT_ELO;
            s.wait_count = load_wait(WAIT_W'(cfg_i.pulse_us));
          end
          PH_INIT_ELO: begin
            s.phase      = PH_INIT_WAIT;
            s.wait_count = load_wait((s.init_step == STEP_FIRST_NIB)
                                     ? WAIT_W'(cfg_i.init_long_wait_us)
                                     : WAIT_W'(cfg_i.init_short_wait_us));
          end
          PH_INIT_WAIT: begin
            if (s.init_step < STEP_LAST_NIB) begin
              s.init_step  = s.init_step + 4'd1;
              s.phase      = PH_INIT_EHI;
              s.wait_count = load_wait(WAIT_W'(cfg_i.pulse_us));
            end else begin
              s.init_step = STEP_FIRST_CMD;
              s = start_byte(s, CMD_FUNC_SET, 1'b0);
            end
          end
          PH_SETUP: begin
            s.phase      = PH_EHI;
            s.wait_count = load_wait(WAIT_W'(cfg_i.pulse_us));
          end
          PH_EHI: begin
            s.phase      = PH_ELO;
            s.wait_count = load_wait(WAIT_W'(cfg_i.pulse_us));
          end
          PH_ELO: begin
            s.phase      = PH_GAP;
            s.wait_count = load_wait(WAIT_W'(cfg_i.nibble_gap_us));
          end
          PH_GAP: begin
            if (!s.low_half_next) begin
              s.low_half_next = 1'b1;
              s.phase         = PH_EHI;
              s.wait_count    = load_wait(WAIT_W'(cfg_i.pulse_us));
            end else begin
              s.phase      = PH_POST;
              s.wait_count = load_wait(s.post_long ? WAIT_W'(cfg_i.clear_delay_us)
                                                   : WAIT_W'(cfg_i.cmd_delay_us));
            end
          end
          PH_POST: begin
            if (s.init_step >= STEP_FIRST_CMD && s.init_step <= STEP_LAST_CMD) begin
              s.phase      = PH_EXTRA;
              s.wait_count = load_wait((s.init_step <= STEP_SLOW_CMD)
                                       ? WAIT_W'(cfg_i.init_cmd_wait_us)
                                       : WAIT_W'(cfg_i.init_short_wait_us));
            end else begin
              s.init_step  = STEP_NONE;
              s.phase      = PH_IDLE;
              s.wait_count = '0;
            end
          end
          PH_EXTRA: begin
            if (s.init_step >= STEP_FIRST_CMD && s.init_step < STEP_LAST_CMD) begin
              s.init_step = s.init_step + 4'd1;
              s = start_byte(s, init_cmd(3'(s.init_step - STEP_FIRST_CMD)), 1'b0);
            end else begin
              s.init_step  = STEP_NONE;
              s.phase      = PH_IDLE;
              s.wait_count = '0;
            end
          end
          default: begin
            s.phase      = PH_IDLE;
            s.wait_count = '0;
          end
        endcase
      end
    end
  end

  assign state_o = s;

  // result of this tick
  always_comb begin
    res_o.rs_pin        = s.pin_rs;
    res_o.enable_pin    = s.pin_e;
    res_o.data_pins     = s.pin_data;
    res_o.backlight_pin = s.backlight_level;
    res_o.busy_res      = (s.phase != PH_IDLE);
    res_o.rejected      = rejected;
  end

endmodule

// File: rtl/char_lcd_four_bit_sequencer.sv
// top level of the 4-bit character lcd sequencer
// depends on clcd_pkg, clcd_req_if, clcd_res_if, clcd_cfg, clcd_step and the macros header

// Each transfer on req_i is one microsecond tick of a 20x4 character panel
// driver on a 4-bit bus and may carry a request (init, command byte, data byte,
// cursor, display control or backlight). Every tick yields exactly one transfer
// on res_o with the RS, E, D7..D4 and backlight levels plus busy and rejected
// flags. The block takes one tick per clock cycle: the sequencer state and the
// timing count advance in a single pass of logic into the state register, and
// a one-entry result register decouples the two channels, so a tick is
// accepted in every cycle in which res_o is empty or being taken. Requests
// arriving while busy_res was set are refused and flagged. Timing registers
// are to be written via cfg_we_i/cfg_idx_i/cfg_wdata_i only while no sequence
// runs, which the block does not enforce; a value of zero counts as one tick.
`include "char_lcd_four_bit_sequencer_macros.svh"

module char_lcd_four_bit_sequencer
  import clcd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [WAIT_W-1:0] cfg_wdata_i,
  clcd_req_if.sink          req_i,
  clcd_res_if.source        res_o
);

  clcd_cfg_t   cfg;
  clcd_req_t   req;
  clcd_state_t state_q;
  clcd_state_t state_d;
  clcd_res_t   res_d;
  clcd_res_t   res_q;
  logic        res_valid_q;
  logic        accept;

  // timing registers
  clcd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // gather the request fields
  always_comb begin
    req.command      = req_i.command;
    req.value        = req_i.value;
    req.col          = req_i.col;
    req.line         = req_i.line;
    req.disp_en      = req_i.disp_en;
    req.curs_en      = req_i.curs_en;
    req.blink_en     = req_i.blink_en;
    req.backlight_on = req_i.backlight_on;
  end

  // one tick of sequencing
  clcd_step u_step (
    .state_i(state_q),
    .cfg_i  (cfg),
    .req_i  (req),
    .state_o(state_d),
    .res_o  (res_d)
  );

  // input transfer whenever the result register is free or being drained
  assign req_i.ready = !res_valid_q || res_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, default: '0};
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (accept) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  // output channel
  assign res_o.valid         = res_valid_q;
  assign res_o.rs_pin        = res_q.rs_pin;
  assign res_o.enable_pin    = res_q.enable_pin;
  assign res_o.data_pins     = res_q.data_pins;
  assign res_o.backlight_pin = res_q.backlight_pin;
  assign res_o.busy_res      = res_q.busy_res;
  assign res_o.rejected      = res_q.rejected;

  // a refused request leaves the backlight level alone
  `CLCD_ASSERT_NEXT(a_reject_keeps_bl, accept && res_d.rejected, state_q.backlight_level == $past(state_q.backlight_level), "refused request changed backlight")
  // a running phase always has time left, idle never does
  `CLCD_ASSERT(a_idle_count, (state_q.phase == PH_IDLE) == (state_q.wait_count == '0), "wait count out of step with phase")
  // init progress only exists while a sequence runs
  `CLCD_ASSERT(a_init_busy, (state_q.init_step == STEP_NONE) || (state_q.phase != PH_IDLE), "init step left set while idle")
  // the busy flag delivered matches the stored phase
  `CLCD_ASSERT_NEXT(a_busy_match, accept, res_q.busy_res == (state_q.phase != PH_IDLE), "busy flag disagrees with phase")

endmodule
